FILE: hdl/lztd_pkg.sv
// ----------------------------------------------------------------------------
// lztd_pkg
// shared types and constants of the lz77 token decoder
// ----------------------------------------------------------------------------
package lztd_pkg;

  localparam int unsigned DIST_W = 16;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SIZE_W = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DIST = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_FAILED   = 2'd3
  } status_e;

  // one result transaction
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    status_e           status;
    logic              last;
  } result_t;

endpackage

FILE: hdl/lztd_hist_mem.sv
// ----------------------------------------------------------------------------
// lztd_hist_mem
// history window ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lztd_hist_mem
  import lztd_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lztd_out_reg.sv
// ----------------------------------------------------------------------------
// lztd_out_reg
// output register stage for result transactions
// ----------------------------------------------------------------------------
module lztd_out_reg
  import lztd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  input  logic    stall_i,
  output logic    valid_o,
  output result_t data_o,
  output logic    free_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // slot can take a new result if empty or drained this cycle
  assign free_o  = !valid_q || !stall_i;
  assign valid_d = push_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hdl/lz77_token_decoder.sv
// ----------------------------------------------------------------------------
// lz77_token_decoder
// lz77 token decoder with a circular history window in block ram
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  token   | in        | in_valid_i / in_stall_o    | back_distance, copy_length,
//          |           |                            | literal_byte
//  result  | out       | out_valid_o / out_stall_i  | out_byte, status, last_of_token
//  config  | in        | cfg_we_i (no wait)         | cfg_wdata_i -> total_size
//
//  a token is captured in idle and checked in decode; each copied byte
//  then takes a history read and an emit step, and the appended literal
//  goes out last. a single-result token ends in decode. each copied byte
//  is a history read followed by its write back; the registered ram read sets the pace
//  the token channel is stalled while a token is in work
//  a stalled result holds the decoder at the byte that wants to go out
//  reset clears control state only; history has no clearing pass
//
// ----------------------------------------------------------------------------
module lz77_token_decoder
  import lztd_pkg::*;
#(
  parameter int unsigned WINDOW  = 4096,
  parameter int unsigned MAX_LEN = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // token channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DIST_W-1:0] back_distance_i,
  input  logic [LEN_W-1:0]  copy_length_i,
  input  logic [BYTE_W-1:0] literal_byte_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic [1:0]        status_o,
  output logic              last_of_token_o,
  // configuration
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(WINDOW);
  // pointer arithmetic width, holds wr_ptr + WINDOW
  localparam int unsigned EW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_EMIT,
    S_LIT
  } state_e;

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] produced_q, produced_d;
  logic              failed_q, failed_d;
  logic [SIZE_W-1:0] total_size_q;
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;

  // token payload
  logic [DIST_W-1:0] dist_q;
  logic [LEN_W-1:0]  len_q;
  logic [BYTE_W-1:0] lit_q;
  logic [LEN_W-1:0]  len_sat;

  logic              accept;
  logic              push;
  result_t           res;
  result_t           out_data;
  logic              slot_free;

  logic              mem_we;
  logic              mem_re;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;

  logic              out_full;
  logic              full_after;
  logic              bad_dist;
  logic [EW-1:0]     wr_ext;
  logic [EW-1:0]     dist_ext;
  logic [EW-1:0]     start_ext;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign len_sat = (copy_length_i > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : copy_length_i;

  // output already at its limit, and limit reached after one more byte
  assign out_full   = (produced_q >= total_size_q);
  assign full_after = (({1'b0, produced_q} + (SIZE_W+1)'(1)) >= {1'b0, total_size_q});

  assign bad_dist = (dist_q == '0) || (SIZE_W'(dist_q) > produced_q) ||
                    (SIZE_W'(dist_q) > SIZE_W'(WINDOW));

  // copy source: wr_ptr - dist, modulo the window
  assign wr_ext    = EW'(wr_ptr_q);
  assign dist_ext  = EW'(dist_q);
  assign start_ext = (wr_ext >= dist_ext) ? (wr_ext - dist_ext)
                                          : (wr_ext + EW'(WINDOW) - dist_ext);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(WINDOW - 1)) ? '0 : p + AW'(1);
    return r;
  endfunction

  always_comb begin
    state_d    = state_q;
    produced_d = produced_q;
    failed_d   = failed_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    cnt_d      = cnt_q;
    push       = 1'b0;
    res        = '{out_byte: '0, status: ST_OK, last: 1'b1};
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata  = lit_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        if (failed_q) begin
          // sticky failure, one status result per token
          res.status = ST_FAILED;
          if (slot_free) begin
            push    = 1'b1;
            state_d = S_IDLE;
          end
        end else if (len_q == '0) begin
          // literal-only token
          if (out_full) begin
            res.status = ST_OVERFLOW;
          end else begin
            res.out_byte = lit_q;
          end
          if (slot_free) begin
            push    = 1'b1;
            state_d = S_IDLE;
            if (out_full) begin
              failed_d = 1'b1;
            end else begin
              mem_we     = 1'b1;
              produced_d = produced_q + SIZE_W'(1);
              wr_ptr_d   = ptr_inc(wr_ptr_q);
            end
          end
        end else if (bad_dist) begin
          res.status = ST_BAD_DIST;
          if (slot_free) begin
            push     = 1'b1;
            failed_d = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          rd_ptr_d = start_ext[AW-1:0];
          cnt_d    = len_q;
          state_d  = S_READ;
        end
      end

      S_READ: begin
        if (out_full) begin
          // copy runs past the configured size
          res.status = ST_OVERFLOW;
          if (slot_free) begin
            push     = 1'b1;
            failed_d = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          mem_re  = 1'b1;
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        // ram data holds here until the byte goes out
        res.out_byte = mem_rdata;
        res.last     = (cnt_q == LEN_W'(1)) && full_after;
        mem_wdata    = mem_rdata;
        if (slot_free) begin
          push       = 1'b1;
          mem_we     = 1'b1;
          produced_d = produced_q + SIZE_W'(1);
          wr_ptr_d   = ptr_inc(wr_ptr_q);
          rd_ptr_d   = ptr_inc(rd_ptr_q);
          cnt_d      = cnt_q - LEN_W'(1);
          if (cnt_q == LEN_W'(1)) begin
            // literal dropped when the output is full after the copy
            state_d = full_after ? S_IDLE : S_LIT;
          end else begin
            state_d = S_READ;
          end
        end
      end

      S_LIT: begin
        res.out_byte = lit_q;
        if (slot_free) begin
          push       = 1'b1;
          mem_we     = 1'b1;
          produced_d = produced_q + SIZE_W'(1);
          wr_ptr_d   = ptr_inc(wr_ptr_q);
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      produced_q   <= '0;
      failed_q     <= 1'b0;
      total_size_q <= '0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      cnt_q        <= '0;
    end else begin
      state_q    <= state_d;
      produced_q <= produced_d;
      failed_q   <= failed_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
      if (cfg_we_i) begin
        total_size_q <= cfg_wdata_i;
      end
    end
  end

  // token capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dist_q <= back_distance_i;
      len_q  <= len_sat;
      lit_q  <= literal_byte_i;
    end
  end

  lztd_hist_mem #(
    .DEPTH (WINDOW)
  ) u_hist_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  lztd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (out_data),
    .free_o  (slot_free)
  );

  assign out_byte_o      = out_data.out_byte;
  assign status_o        = out_data.status;
  assign last_of_token_o = out_data.last;

  // a result is only loaded into a free output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> slot_free)
    else $error("result pushed into occupied output register");

  // failure is sticky until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni) failed_q |=> failed_q)
    else $error("failed flag cleared without reset");

  // every history read is followed by the cycle that consumes its data
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_re |=> (state_q == S_EMIT))
    else $error("history read not followed by emit");

  // error results always close their token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> last_of_token_o)
    else $error("error result without end of token");

endmodule

FILE: test/lz77_token_decoder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz77_token_decoder_checker
// watches the token, result and config ports of the lz77 token decoder,
// decodes every accepted token on its own and compares each result
// transaction against the oldest decoded byte still due
// ----------------------------------------------------------------------------
module lz77_token_decoder_checker
  import lztd_pkg::*;
#(
  parameter int unsigned WINDOW  = 4096,
  parameter int unsigned MAX_LEN = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [DIST_W-1:0] back_distance_i,
  input  logic [LEN_W-1:0]  copy_length_i,
  input  logic [BYTE_W-1:0] literal_byte_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [BYTE_W-1:0] out_byte_i,
  input  logic [1:0]        status_i,
  input  logic              last_of_token_i,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o,
  output int unsigned       results_seen_o
);

  localparam int unsigned AW = $clog2(WINDOW);

  // own copy of the decoder state
  logic [BYTE_W-1:0] window_mem [WINDOW];
  logic [SIZE_W-1:0] bytes_emitted;
  logic [SIZE_W-1:0] size_limit;
  logic              decoder_dead;

  result_t     decoded_q[$];
  int unsigned mismatches;
  int unsigned results_seen;

  function automatic void push_decoded(input logic [BYTE_W-1:0] b, input status_e st,
                                       input logic last);
    result_t r;
    r.out_byte = b;
    r.status   = st;
    r.last     = last;
    decoded_q.push_back(r);
  endfunction

  function automatic void append_byte(input logic [BYTE_W-1:0] b);
    window_mem[AW'(bytes_emitted % WINDOW)] = b;
    bytes_emitted++;
  endfunction

  function automatic void decode_token(input logic [DIST_W-1:0] back_dist,
                                       input logic [LEN_W-1:0]  len_in,
                                       input logic [BYTE_W-1:0] lit);
    int unsigned      run_len;
    int unsigned      j;
    logic [BYTE_W-1:0] b;
    if (decoder_dead) begin
      push_decoded('0, ST_FAILED, 1'b1);
      return;
    end
    run_len = (len_in > MAX_LEN) ? MAX_LEN : len_in;
    if (run_len == 0) begin
      if (bytes_emitted >= size_limit) begin
        decoder_dead = 1'b1;
        push_decoded('0, ST_OVERFLOW, 1'b1);
        return;
      end
      append_byte(lit);
      push_decoded(lit, ST_OK, 1'b1);
      return;
    end
    if (back_dist == 0 || back_dist > bytes_emitted || back_dist > WINDOW) begin
      decoder_dead = 1'b1;
      push_decoded('0, ST_BAD_DIST, 1'b1);
      return;
    end
    for (j = 0; j < run_len; j++) begin
      if (bytes_emitted >= size_limit) begin
        decoder_dead = 1'b1;
        push_decoded('0, ST_OVERFLOW, 1'b1);
        return;
      end
      b = window_mem[AW'((bytes_emitted - back_dist) % WINDOW)];
      append_byte(b);
      // output full after the copy: literal dropped, last copy byte closes the token
      push_decoded(b, ST_OK, (j == run_len - 1) && (bytes_emitted >= size_limit));
    end
    if (bytes_emitted < size_limit) begin
      append_byte(lit);
      push_decoded(lit, ST_OK, 1'b1);
    end
  endfunction

  function automatic void report_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
    mismatches++;
    $display("time %0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      bytes_emitted = '0;
      size_limit    = '0;
      decoder_dead  = 1'b0;
      decoded_q.delete();
      mismatches    = 0;
      results_seen  = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
      results_seen_o   <= 0;
    end else begin
      if (cfg_we_i)
        size_limit = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        decode_token(back_distance_i, copy_length_i, literal_byte_i);
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          mismatches++;
          $display("time %0t: expected no result, actual out_byte %0h status %0d last %0d",
                   $time, out_byte_i, status_i, last_of_token_i);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_i !== want.out_byte)
            report_mismatch("out_byte", want.out_byte, out_byte_i);
          if (status_i !== want.status)
            report_mismatch("status", want.status, status_i);
          if (last_of_token_i !== want.last)
            report_mismatch("last_of_token", want.last, last_of_token_i);
        end
      end
      mismatch_count_o <= mismatches;
      pending_o        <= decoded_q.size();
      results_seen_o   <= results_seen;
    end
  end

endmodule

FILE: test/tb_lz77_token_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lz77_token_decoder
// regression for the lz77 token decoder: directed tokens around the edges,
// then phases of random well-formed tokens under changing output size
// limits, closed by one fatal error and tokens into the failed decoder;
// results are checked by lz77_token_decoder_checker
// ----------------------------------------------------------------------------
module tb_lz77_token_decoder;
  import lztd_pkg::*;

  localparam int unsigned WINDOW        = 4096;
  localparam int unsigned MAX_LEN       = 63;
  localparam int unsigned RANDOM_TOKENS = 380;
  // the last random tokens run with neither sender gaps nor result stalls
  localparam int unsigned CALM_TOKENS   = 60;
  // covers the longest tokens with results stalled by the longest bursts
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned DRAIN_CYCLES  = 2 * MAX_LEN + 40;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [DIST_W-1:0] back_distance_i;
  logic [LEN_W-1:0]  copy_length_i;
  logic [BYTE_W-1:0] literal_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BYTE_W-1:0] out_byte_o;
  logic [1:0]        status_o;
  logic              last_of_token_o;
  logic              cfg_we_i;
  logic [SIZE_W-1:0] cfg_wdata_i;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned results_seen;

  // stimulus side bookkeeping: how much output exists and what the size limit is,
  // so that random tokens only use distances that are legal right now
  logic [SIZE_W-1:0] size_cap;
  int unsigned       bytes_out;
  int unsigned       bytes_before_close;
  int unsigned       tokens_sent;
  int unsigned       cfg_writes;
  bit                gaps_on;
  bit                stalls_on;
  string             fatal_kind;

  lz77_token_decoder #(
    .WINDOW (WINDOW),
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .back_distance_i(back_distance_i),
    .copy_length_i  (copy_length_i),
    .literal_byte_i (literal_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .last_of_token_o(last_of_token_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  lz77_token_decoder_checker #(
    .WINDOW (WINDOW),
    .MAX_LEN(MAX_LEN)
  ) u_decode_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .back_distance_i (back_distance_i),
    .copy_length_i   (copy_length_i),
    .literal_byte_i  (literal_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_i      (out_byte_o),
    .status_i        (status_o),
    .last_of_token_i (last_of_token_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_results),
    .results_seen_o  (results_seen)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycles, pending_results);
    $display("lz77_token_decoder regression: fail");
    $finish;
  end

  // result side back-pressure: random stall bursts while stalls are on
  initial begin : result_stalls
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stalls_on && rst_ni && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // one token transaction; may open with a sender gap, returns at the
  // accepting edge with valid still high so back-to-back tokens stay dense
  task automatic send_token(input logic [DIST_W-1:0] back_dist, input logic [LEN_W-1:0] len,
                            input logic [BYTE_W-1:0] lit);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    back_distance_i <= back_dist;
    copy_length_i   <= len;
    literal_byte_i  <= lit;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tokens_sent++;
    // tally the output the token adds; the literal after a copy is dropped when full
    if (len == 0) begin
      bytes_out++;
    end else begin
      bytes_out += len;
      if (bytes_out < size_cap)
        bytes_out++;
    end
  endtask

  // hold the sender until every decoded byte has come out, then let the
  // decoder settle for as long as the settle argument asks
  task automatic drain_results(input int unsigned settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // total_size write; only called while the decoder is idle
  task automatic write_size(input logic [SIZE_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_cap = value;
    cfg_writes++;
  endtask

  // a legal copy distance, leaning toward the nearest and farthest reach
  function automatic logic [DIST_W-1:0] pick_distance();
    int unsigned reach;
    reach = (bytes_out < WINDOW) ? bytes_out : WINDOW;
    case ($urandom_range(0, 7))
      0:       return 1;
      1:       return reach;
      2:       return $urandom_range(1, (reach < 8) ? reach : 8);
      default: return $urandom_range(1, reach);
    endcase
  endfunction

  // random well-formed token that fits in the room left under the size limit
  task automatic random_token();
    logic [DIST_W-1:0] back_dist;
    logic [LEN_W-1:0]  len;
    int unsigned       room;
    room = size_cap - bytes_out;
    if (bytes_out == 0 || $urandom_range(0, 3) == 0) begin
      // literal only: the distance is ignored, so any value goes
      len       = '0;
      back_dist = DIST_W'($urandom_range(0, 65535));
    end else begin
      case ($urandom_range(0, 5))
        0:       len = LEN_W'(MAX_LEN);
        1:       len = LEN_W'(1);
        default: len = LEN_W'($urandom_range(1, MAX_LEN));
      endcase
      if (len > room)
        len = LEN_W'(room);
      back_dist = pick_distance();
    end
    send_token(back_dist, len, BYTE_W'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int unsigned       tokens_left;
    int unsigned       phase_len;
    logic [SIZE_W-1:0] cap;

    in_valid_i      <= 1'b0;
    back_distance_i <= '0;
    copy_length_i   <= '0;
    literal_byte_i  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    rst_ni          <= 1'b0;
    size_cap    = '0;
    bytes_out   = 0;
    bytes_before_close = 0;
    tokens_sent = 0;
    cfg_writes  = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    fatal_kind  = "";

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // size limit at both ends before any token
    write_size('0);
    write_size('1);

    // literal-only tokens with extreme bytes; the distance is ignored
    send_token(16'hFFFF, '0, 8'h00);
    send_token(16'h0000, '0, 8'hFF);
    send_token(16'h8000, '0, 8'hA5);
    send_token(16'h7FFF, '0, 8'h5A);
    // shortest copy, then a copy reaching back to the very first byte
    send_token(16'd1, 6'd1, 8'h3C);
    send_token(DIST_W'(bytes_out), 6'd6, 8'hC3);
    // longest copies, overlapping their own output, then a shorter copy from further back
    send_token(16'd1, 6'(MAX_LEN), 8'h81);
    send_token(16'd2, 6'(MAX_LEN), 8'h7E);
    send_token(16'd77, 6'd40, 8'h99);

    // copy that fills the output exactly: literal dropped, last copy byte ends it
    drain_results(4);
    write_size(bytes_out + 5);
    send_token(16'd3, 6'd5, 8'hE7);
    // copy plus literal that land exactly on the limit
    drain_results(4);
    write_size(bytes_out + 9);
    send_token(16'd1, 6'd8, 8'h18);
    drain_results(4);
    write_size('1);

    // ---- random part: phases, each under its own size limit ----
    tokens_left = RANDOM_TOKENS;
    while (tokens_left > 0) begin
      drain_results(4);
      case ($urandom_range(0, 3))
        0:       cap = '1;
        default: cap = bytes_out + $urandom_range(40, 1500);
      endcase
      write_size(cap);
      // some phases run without idling on one or both sides
      gaps_on   = (tokens_left > CALM_TOKENS) && ($urandom_range(0, 3) != 0);
      stalls_on = (tokens_left > CALM_TOKENS) && ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(15, 70);
      while (phase_len > 0 && tokens_left > 0 && size_cap != bytes_out) begin
        if (tokens_left == CALM_TOKENS) begin
          gaps_on   = 1'b0;
          stalls_on = 1'b0;
        end
        random_token();
        phase_len--;
        tokens_left--;
      end
    end

    // ---- closing part: one fatal error, then the decoder stays failed ----
    drain_results(4);
    bytes_before_close = bytes_out;
    case ($urandom_range(0, 4))
      0: begin
        fatal_kind = "zero distance";
        send_token('0, 6'($urandom_range(1, MAX_LEN)), $urandom_range(0, 255));
      end
      1: begin
        fatal_kind = "distance past the produced output";
        send_token(DIST_W'(bytes_out + 1), 6'($urandom_range(1, MAX_LEN)),
                   $urandom_range(0, 255));
      end
      2: begin
        fatal_kind = "distance past the window";
        send_token($urandom_range(WINDOW + 1, 65535), 6'($urandom_range(1, MAX_LEN)),
                   $urandom_range(0, 255));
      end
      3: begin
        fatal_kind = "literal into a zero size limit";
        write_size('0);
        send_token($urandom_range(0, 65535), '0, $urandom_range(0, 255));
      end
      default: begin
        fatal_kind = "overflow in the middle of a copy";
        write_size(bytes_out + $urandom_range(1, 30));
        send_token(pick_distance(), 6'(MAX_LEN), $urandom_range(0, 255));
      end
    endcase
    repeat (6)
      send_token($urandom_range(0, 65535), $urandom_range(0, MAX_LEN), $urandom_range(0, 255));

    drain_results(DRAIN_CYCLES);

    $display("run covered %0d tokens, %0d size limit writes, %0d result transactions",
             tokens_sent, cfg_writes, results_seen);
    $display("output reached %0d bytes; closed with %s and tokens into the failed decoder",
             bytes_before_close, fatal_kind);
    if (mismatch_count == 0) begin
      $display("lz77_token_decoder regression: pass");
    end else begin
      $display("lz77_token_decoder regression: fail");
    end
    $finish;
  end

endmodule

FILE: lz77_token_decoder.f
hdl/lztd_pkg.sv
hdl/lztd_hist_mem.sv
hdl/lztd_out_reg.sv
hdl/lz77_token_decoder.sv
test/lz77_token_decoder_checker.sv
test/tb_lz77_token_decoder.sv
